// ===== design/gbns_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbns_pkg
// Shared constants, codes, types and helpers of the go-back-n sender.
// ---------------------------------------------------------------------------
package gbns_pkg;

    localparam int PAYLOAD_BYTES  = 1024;
    localparam int WINDOW_PACKETS = 5;
    localparam int SEQ_LIMIT      = 30720;

    localparam int MAX_RESULTS = 8;
    localparam int MAX_COUNT   = 32766;

    localparam int SEQ_W   = 15;
    localparam int SUM_W   = SEQ_W + 2;
    localparam int IDX_W   = 15;
    localparam int SIZE_W  = 24;
    localparam int PAY_W   = 11;
    localparam int PAY_SH  = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

    // input kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PACKET  = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_LAST = 2'd0;
    localparam logic [1:0] STATUS_MORE = 2'd1;
    localparam logic [1:0] STATUS_CTRL = 2'd2;

    // configuration register indexes
    localparam logic CFG_SERVER_SEQ = 1'b0;
    localparam logic CFG_CLIENT_SEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FIN_ACK,
        ST_FIN_FIN,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic load_in;
        logic apply;
        logic emit_fin_ack;
        logic emit_fin_fin;
        logic emit_data;
    } cmd_t;

    typedef struct packed {
        logic evt_fin;
        logic fill_ok;
        logic last_data;
        logic out_free;
    } stat_t;

    // sum wrap: values above the limit fold back by one limit
    function automatic logic [SEQ_W-1:0] seq_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = s;
        if (s > SUM_W'(SEQ_LIMIT)) begin
            r = s - SUM_W'(SEQ_LIMIT);
        end
        return r[SEQ_W-1:0];
    endfunction

endpackage

// ===== design/gbns_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbns_ctrl
// Sequencer: takes one request, applies it, then emits control or data
// headers one at a time into the output register.
// ---------------------------------------------------------------------------
module gbns_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  gbns_pkg::stat_t  stat,
    output gbns_pkg::cmd_t   cmd
);

    gbns_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbns_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            gbns_pkg::ST_IDLE: begin
                // no request is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_in = 1'b1;
                    state_next  = gbns_pkg::ST_EVAL;
                end
            end
            gbns_pkg::ST_EVAL: begin
                cmd.apply  = 1'b1;
                state_next = stat.evt_fin ? gbns_pkg::ST_FIN_ACK : gbns_pkg::ST_FILL;
            end
            gbns_pkg::ST_FIN_ACK: begin
                if (stat.out_free) begin
                    cmd.emit_fin_ack = 1'b1;
                    state_next       = gbns_pkg::ST_FIN_FIN;
                end
            end
            gbns_pkg::ST_FIN_FIN: begin
                if (stat.out_free) begin
                    cmd.emit_fin_fin = 1'b1;
                    state_next       = gbns_pkg::ST_IDLE;
                end
            end
            gbns_pkg::ST_FILL: begin
                if (!stat.fill_ok) begin
                    state_next = gbns_pkg::ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit_data = 1'b1;
                    if (stat.last_data) begin
                        state_next = gbns_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = gbns_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/gbns_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbns_dpath
// Window state, sequence registers, request latch and result register.
// ---------------------------------------------------------------------------
module gbns_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic                                  cfg_addr,
    input  logic [gbns_pkg::SEQ_W-1:0]            cfg_wdata,
    input  logic [gbns_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gbns_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast,
    input  gbns_pkg::cmd_t                        cmd,
    output gbns_pkg::stat_t                       stat
);

    localparam int SEQ_W = gbns_pkg::SEQ_W;
    localparam int SUM_W = gbns_pkg::SUM_W;
    localparam int IDX_W = gbns_pkg::IDX_W;
    localparam int PAY_W = gbns_pkg::PAY_W;
    localparam int PAY_SH = gbns_pkg::PAY_SH;
    localparam int CNT_W = gbns_pkg::CNT_W;
    localparam int SIZE_W = gbns_pkg::SIZE_W;

    // configuration registers
    logic [SEQ_W-1:0] srv_seq_reg, srv_seq_next;
    logic [SEQ_W-1:0] cli_seq_reg, cli_seq_next;

    // window state
    logic             active_reg, active_next;
    logic [IDX_W-1:0] base_idx_reg, base_idx_next;
    logic [IDX_W-1:0] next_idx_reg, next_idx_next;
    logic [IDX_W-1:0] total_reg, total_next;
    logic [PAY_W-1:0] tail_reg, tail_next;
    logic [SEQ_W-1:0] base_seq_reg, base_seq_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;

    // request latch
    logic [1:0]        kind_reg;
    logic [SIZE_W-1:0] fsize_reg;
    logic              ackf_reg;
    logic              finf_reg;
    logic [SEQ_W-1:0]  ackn_reg;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic [SEQ_W-1:0] m_seq_reg, m_seq_next;
    logic [SEQ_W-1:0] m_ack_reg, m_ack_next;
    logic             m_abit_reg, m_abit_next;
    logic             m_fbit_reg, m_fbit_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [PAY_W-1:0] m_size_reg, m_size_next;
    logic [IDX_W-1:0] m_index_reg, m_index_next;
    logic             m_last_reg, m_last_next;

    // derived values
    logic [SEQ_W-1:0]  expect_seq;
    logic              ack_match;
    logic [SEQ_W-1:0]  cli_plus;
    logic [SEQ_W-1:0]  srv_plus;
    logic [SEQ_W-1:0]  next_seq_plus;
    logic [IDX_W:0]    window_end;
    logic [IDX_W:0]    next_idx_inc;
    logic              tail_pkt;
    logic [PAY_SH-1:0] rem;
    logic              rem_nz;
    logic [SIZE_W:0]   cnt_wide;
    logic              cnt_sat;
    logic [IDX_W-1:0]  cnt;

    assign expect_seq    = gbns_pkg::seq_wrap(SUM_W'(base_seq_reg)
                                              + SUM_W'(gbns_pkg::PAYLOAD_BYTES));
    assign ack_match     = ackf_reg && (ackn_reg == expect_seq);
    assign cli_plus      = gbns_pkg::seq_wrap(SUM_W'(cli_seq_reg) + SUM_W'(1));
    assign srv_plus      = gbns_pkg::seq_wrap(SUM_W'(srv_seq_reg) + SUM_W'(1));
    assign next_seq_plus = gbns_pkg::seq_wrap(SUM_W'(next_seq_reg)
                                              + SUM_W'(gbns_pkg::PAYLOAD_BYTES));
    assign window_end    = {1'b0, base_idx_reg} + (IDX_W+1)'(gbns_pkg::WINDOW_PACKETS);
    assign next_idx_inc  = {1'b0, next_idx_reg} + (IDX_W+1)'(1);
    assign tail_pkt      = (next_idx_reg == total_reg);

    // packet count of a new transfer, rounded up and saturated
    assign rem      = fsize_reg[PAY_SH-1:0];
    assign rem_nz   = (rem != '0);
    assign cnt_wide = (SIZE_W+1)'(fsize_reg >> PAY_SH) + (SIZE_W+1)'(rem_nz);
    assign cnt_sat  = (cnt_wide > (SIZE_W+1)'(gbns_pkg::MAX_COUNT));
    assign cnt      = cnt_sat ? IDX_W'(gbns_pkg::MAX_COUNT) : cnt_wide[IDX_W-1:0];

    always_comb begin
        stat.evt_fin  = (kind_reg == gbns_pkg::KIND_PACKET) && active_reg
                        && !ack_match && finf_reg;
        stat.fill_ok  = active_reg && (kind_reg != gbns_pkg::KIND_UNUSED)
                        && (next_idx_reg <= total_reg)
                        && ({1'b0, next_idx_reg} < window_end)
                        && (run_cnt_reg < CNT_W'(gbns_pkg::MAX_RESULTS));
        stat.last_data = (run_cnt_reg == CNT_W'(gbns_pkg::MAX_RESULTS - 1))
                        || (next_idx_inc > {1'b0, total_reg})
                        || (next_idx_inc >= window_end);
        stat.out_free = !m_valid_reg || m_tready;
    end

    always_comb begin
        srv_seq_next  = srv_seq_reg;
        cli_seq_next  = cli_seq_reg;
        active_next   = active_reg;
        base_idx_next = base_idx_reg;
        next_idx_next = next_idx_reg;
        total_next    = total_reg;
        tail_next     = tail_reg;
        base_seq_next = base_seq_reg;
        next_seq_next = next_seq_reg;
        run_cnt_next  = run_cnt_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_seq_next    = m_seq_reg;
        m_ack_next    = m_ack_reg;
        m_abit_next   = m_abit_reg;
        m_fbit_next   = m_fbit_reg;
        m_status_next = m_status_reg;
        m_size_next   = m_size_reg;
        m_index_next  = m_index_reg;
        m_last_next   = m_last_reg;

        if (cfg_we) begin
            if (cfg_addr == gbns_pkg::CFG_SERVER_SEQ) begin
                srv_seq_next = cfg_wdata;
            end else begin
                cli_seq_next = cfg_wdata;
            end
        end

        if (cmd.load_in) begin
            run_cnt_next = '0;
        end

        if (cmd.apply) begin
            unique case (kind_reg)
                gbns_pkg::KIND_START: begin
                    total_next    = cnt;
                    if (cnt == '0) begin
                        tail_next = '0;
                    end else if (rem_nz && !cnt_sat) begin
                        tail_next = PAY_W'(rem);
                    end else begin
                        tail_next = PAY_W'(gbns_pkg::PAYLOAD_BYTES);
                    end
                    active_next   = 1'b1;
                    base_idx_next = IDX_W'(1);
                    next_idx_next = IDX_W'(1);
                    base_seq_next = gbns_pkg::seq_wrap(SUM_W'(srv_seq_reg));
                    next_seq_next = gbns_pkg::seq_wrap(SUM_W'(srv_seq_reg));
                end
                gbns_pkg::KIND_PACKET: begin
                    if (active_reg) begin
                        priority if (ack_match) begin
                            if (base_idx_reg < gbns_pkg::INDEX_MAX) begin
                                base_idx_next = base_idx_reg + IDX_W'(1);
                                base_seq_next = expect_seq;
                            end
                        end else if (finf_reg) begin
                            active_next = 1'b0;
                        end else begin
                            next_idx_next = base_idx_reg;
                            next_seq_next = base_seq_reg;
                        end
                    end
                end
                gbns_pkg::KIND_TIMEOUT: begin
                    if (active_reg) begin
                        next_idx_next = base_idx_reg;
                        next_seq_next = base_seq_reg;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.emit_fin_ack) begin
            cli_seq_next  = cli_plus;
            m_valid_next  = 1'b1;
            m_seq_next    = srv_seq_reg;
            m_ack_next    = cli_plus;
            m_abit_next   = 1'b1;
            m_fbit_next   = 1'b0;
            m_status_next = gbns_pkg::STATUS_CTRL;
            m_size_next   = '0;
            m_index_next  = '0;
            m_last_next   = 1'b0;
        end

        if (cmd.emit_fin_fin) begin
            srv_seq_next  = srv_plus;
            m_valid_next  = 1'b1;
            m_seq_next    = srv_plus;
            m_ack_next    = cli_seq_reg;
            m_abit_next   = 1'b0;
            m_fbit_next   = 1'b1;
            m_status_next = gbns_pkg::STATUS_CTRL;
            m_size_next   = '0;
            m_index_next  = '0;
            m_last_next   = 1'b1;
        end

        if (cmd.emit_data) begin
            m_valid_next  = 1'b1;
            m_seq_next    = next_seq_reg;
            m_ack_next    = cli_plus;
            m_abit_next   = 1'b1;
            m_fbit_next   = 1'b0;
            m_status_next = tail_pkt ? gbns_pkg::STATUS_LAST : gbns_pkg::STATUS_MORE;
            m_size_next   = tail_pkt ? tail_reg : PAY_W'(gbns_pkg::PAYLOAD_BYTES);
            m_index_next  = next_idx_reg;
            m_last_next   = stat.last_data;
            next_idx_next = next_idx_inc[IDX_W-1:0];
            next_seq_next = next_seq_plus;
            run_cnt_next  = run_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srv_seq_reg  <= '0;
            cli_seq_reg  <= '0;
            active_reg   <= 1'b0;
            base_idx_reg <= IDX_W'(1);
            next_idx_reg <= IDX_W'(1);
            total_reg    <= '0;
            tail_reg     <= '0;
            base_seq_reg <= '0;
            next_seq_reg <= '0;
            run_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            srv_seq_reg  <= srv_seq_next;
            cli_seq_reg  <= cli_seq_next;
            active_reg   <= active_next;
            base_idx_reg <= base_idx_next;
            next_idx_reg <= next_idx_next;
            total_reg    <= total_next;
            tail_reg     <= tail_next;
            base_seq_reg <= base_seq_next;
            next_seq_reg <= next_seq_next;
            run_cnt_reg  <= run_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg  <= s_tuser;
            fsize_reg <= s_tdata[SIZE_W-1:0];
            ackf_reg  <= s_tdata[SIZE_W];
            finf_reg  <= s_tdata[SIZE_W+1];
            ackn_reg  <= s_tdata[SIZE_W+2 +: SEQ_W];
        end
        m_seq_reg    <= m_seq_next;
        m_ack_reg    <= m_ack_next;
        m_abit_reg   <= m_abit_next;
        m_fbit_reg   <= m_fbit_next;
        m_status_reg <= m_status_next;
        m_size_reg   <= m_size_next;
        m_index_reg  <= m_index_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_index_reg, m_size_reg, m_fbit_reg, m_abit_reg,
                       m_ack_reg, m_seq_reg};

endmodule

// ===== design/go_back_n_sender.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// go_back_n_sender
// Go-back-n sender controller: window and header generation for one file.
// ---------------------------------------------------------------------------
// s_ channel takes requests: start (file size), received packet, timeout.
// m_ channel gives packet headers; tlast marks the final header caused by
// one request. A request causes at most eight headers.
// Requests are taken one at a time: s_tready is high only while the
// sequencer is idle. After acceptance the evaluate state applies the
// request to the window state, then headers leave one per cycle through
// a single output register when the receiver does not stall.
// The output register frees in the cycle it is taken, so headers stream
// back to back while m_tready stays high; when the receiver stalls, the
// sequencer holds until the register is taken.
// The cfg_ port writes the server and client sequence registers; write it
// only while no request is in flight.
// Synchronous active-low reset clears the window state, the sequence
// registers and the output valid; s_tready stays low while reset is held.
// ---------------------------------------------------------------------------
module go_back_n_sender (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [gbns_pkg::SEQ_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // byte_count[23:0], ack_flag[24], fin_flag[25], ack_number[40:26]
    input  logic [gbns_pkg::IN_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // seq_number[14:0], ack_number_out[29:15], ack_bit[30], fin_bit[31],
    // payload_size[42:32], packet_index[57:43]
    output logic [gbns_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    gbns_pkg::cmd_t  cmd;
    gbns_pkg::stat_t stat;

    gbns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbns_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a header is only loaded when the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_fin_ack || cmd.emit_fin_fin || cmd.emit_data) |-> stat.out_free)
        else $error("header loaded into a full output register");

    // data headers only inside the window and the file
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_data |-> stat.fill_ok)
        else $error("data header outside the window");

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_in, cmd.apply, cmd.emit_fin_ack, cmd.emit_fin_fin,
                  cmd.emit_data}))
        else $error("conflicting sequencer commands");

endmodule

// ===== verif/go_back_n_sender_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// go_back_n_sender_test
// Self-checking bench for the go-back-n sender. Requests go in on the s_
// stream with random gaps. Every accepted request runs through a local
// window model that queues the headers it should cause. Each header taken
// from the m_ stream is checked field by field against the oldest queued
// one. Directed cases come first, then random transfer sessions under
// several sequence register settings.
// ---------------------------------------------------------------------------
module go_back_n_sender_test;

    typedef struct {
        logic [14:0] seq;
        logic [14:0] ack;
        logic        abit;
        logic        fbit;
        logic [1:0]  status;
        logic [10:0] size;
        logic [14:0] idx;
        logic        last;
    } header_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic                             cfg_addr;
    logic [gbns_pkg::SEQ_W-1:0]       cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [gbns_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]                       s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [gbns_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]                       m_tuser;
    logic                             m_tlast;

    // local window model
    int unsigned srv_seq;
    int unsigned cli_seq;
    bit          xfer_on;
    int unsigned base_idx;
    int unsigned next_idx;
    int unsigned pkt_total;
    int unsigned tail_bytes;
    int unsigned base_sn;
    int unsigned next_sn;

    header_t     pending_hdrs[$];
    int          mismatches;
    int unsigned accepted_items;
    bit          jitter_on;
    int          rx_hold;

    go_back_n_sender u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // sums past the limit fold back into 1..SEQ_LIMIT
    function automatic int unsigned wrap_sn(int unsigned s);
        if (s > gbns_pkg::SEQ_LIMIT) begin
            s = (s - 1) % gbns_pkg::SEQ_LIMIT + 1;
        end
        return s;
    endfunction

    function automatic int unsigned ack_for_base();
        return wrap_sn(base_sn + gbns_pkg::PAYLOAD_BYTES);
    endfunction

    function automatic int unsigned any_size();
        return $urandom_range(0, 24'hFFFFFF);
    endfunction

    function automatic int unsigned any_ack();
        return $urandom_range(0, gbns_pkg::SEQ_LIMIT);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!jitter_on || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic header_t make_hdr(int unsigned seq, int unsigned ack, bit abit,
                                         bit fbit, logic [1:0] status,
                                         int unsigned size, int unsigned idx);
        header_t h;
        h.seq    = seq[14:0];
        h.ack    = ack[14:0];
        h.abit   = abit;
        h.fbit   = fbit;
        h.status = status;
        h.size   = size[10:0];
        h.idx    = idx[14:0];
        h.last   = 1'b0;
        return h;
    endfunction

    function automatic void predict_headers(logic [1:0] kind, logic [23:0] fsize, bit ackf,
                                            bit finf, logic [14:0] ackn);
        header_t     run_hdrs[$];
        header_t     h;
        int unsigned cnt;
        int unsigned rem;
        int unsigned ackout;
        bit          last;
        if (kind == gbns_pkg::KIND_START) begin
            cnt = fsize / gbns_pkg::PAYLOAD_BYTES;
            rem = fsize % gbns_pkg::PAYLOAD_BYTES;
            if (rem != 0) begin
                cnt++;
            end
            if (cnt > gbns_pkg::MAX_COUNT) begin
                cnt = gbns_pkg::MAX_COUNT;
                rem = 0;
            end
            pkt_total  = cnt;
            tail_bytes = (rem != 0) ? rem : gbns_pkg::PAYLOAD_BYTES;
            if (cnt == 0) begin
                tail_bytes = 0;
            end
            xfer_on  = 1'b1;
            base_idx = 1;
            next_idx = 1;
            base_sn  = wrap_sn(srv_seq);
            next_sn  = base_sn;
        end else if (kind == gbns_pkg::KIND_PACKET && xfer_on) begin
            if (ackf && ackn == ack_for_base()) begin
                if (base_idx < 32767) begin
                    base_idx++;
                    base_sn = wrap_sn(base_sn + gbns_pkg::PAYLOAD_BYTES);
                end
            end else if (finf) begin
                // answer the close with an ack header and then our own fin
                cli_seq = wrap_sn(cli_seq + 1);
                run_hdrs.push_back(make_hdr(srv_seq, cli_seq, 1'b1, 1'b0,
                                            gbns_pkg::STATUS_CTRL, 0, 0));
                srv_seq = wrap_sn(srv_seq + 1);
                run_hdrs.push_back(make_hdr(srv_seq, cli_seq, 1'b0, 1'b1,
                                            gbns_pkg::STATUS_CTRL, 0, 0));
                xfer_on = 1'b0;
            end else begin
                next_idx = base_idx;
                next_sn  = base_sn;
            end
        end else if (kind == gbns_pkg::KIND_TIMEOUT && xfer_on) begin
            next_idx = base_idx;
            next_sn  = base_sn;
        end

        if (xfer_on && kind != gbns_pkg::KIND_UNUSED) begin
            ackout = wrap_sn(cli_seq + 1);
            while (run_hdrs.size() < gbns_pkg::MAX_RESULTS && next_idx <= pkt_total &&
                   next_idx < base_idx + gbns_pkg::WINDOW_PACKETS) begin
                last = (next_idx == pkt_total);
                run_hdrs.push_back(make_hdr(next_sn, ackout, 1'b1, 1'b0,
                                            last ? gbns_pkg::STATUS_LAST
                                                 : gbns_pkg::STATUS_MORE,
                                            last ? tail_bytes : gbns_pkg::PAYLOAD_BYTES,
                                            next_idx));
                next_idx++;
                next_sn = wrap_sn(next_sn + gbns_pkg::PAYLOAD_BYTES);
            end
        end

        if (run_hdrs.size() > 0) begin
            h = run_hdrs.pop_back();
            h.last = 1'b1;
            run_hdrs.push_back(h);
        end
        foreach (run_hdrs[i]) begin
            pending_hdrs.push_back(run_hdrs[i]);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : check_headers
        header_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hdrs.size() == 0) begin
                $display("%0t: unexpected header, expected none, actual seq %0d index %0d",
                         $time, m_tdata[14:0], m_tdata[57:43]);
                mismatches++;
            end else begin
                want = pending_hdrs.pop_front();
                check_field("seq_number", want.seq, m_tdata[14:0]);
                check_field("ack_number_out", want.ack, m_tdata[29:15]);
                check_field("ack_bit", want.abit, m_tdata[30]);
                check_field("fin_bit", want.fbit, m_tdata[31]);
                check_field("payload_size", want.size, m_tdata[42:32]);
                check_field("packet_index", want.idx, m_tdata[57:43]);
                check_field("status", want.status, m_tuser);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
    end

    // receiver side: random stalls plus an optional long hold
    initial begin : rx_side
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall = stall - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall = draw_gap();
                end
            end
        end
    end

    task automatic send_request(logic [1:0] kind, int unsigned fsize, int unsigned ackf,
                                int unsigned finf, int unsigned ackn);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, ackn[14:0], finf[0], ackf[0], fsize[23:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == gbns_pkg::KIND_START || (kind != gbns_pkg::KIND_UNUSED && xfer_on)) begin
            accepted_items++;
        end
        predict_headers(kind, fsize[23:0], ackf[0], finf[0], ackn[14:0]);
    endtask

    // block is idle once every header is out and a request with none has settled
    task automatic wait_all_headers();
        s_tvalid <= 1'b0;
        while (pending_hdrs.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, int unsigned value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[14:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (addr == gbns_pkg::CFG_SERVER_SEQ) begin
            srv_seq = value & 32'h7FFF;
        end else begin
            cli_seq = value & 32'h7FFF;
        end
    endtask

    task automatic test_idle_requests();
        send_request(gbns_pkg::KIND_PACKET, any_size(), 1, 0, 1024);
        send_request(gbns_pkg::KIND_TIMEOUT, any_size(), 0, 1, any_ack());
        send_request(gbns_pkg::KIND_UNUSED, any_size(), 1, 1, any_ack());
    endtask

    task automatic test_start_sizes();
        wait_all_headers();
        write_reg(gbns_pkg::CFG_SERVER_SEQ, 0);
        write_reg(gbns_pkg::CFG_CLIENT_SEQ, 0);
        // empty file: active, but nothing to send even after a timeout
        send_request(gbns_pkg::KIND_START, 0, 0, 0, 0);
        send_request(gbns_pkg::KIND_TIMEOUT, 0, 0, 0, 0);
        send_request(gbns_pkg::KIND_START, 1, 0, 0, 0);
        send_request(gbns_pkg::KIND_START, 3 * gbns_pkg::PAYLOAD_BYTES, 0, 0, 0);
        send_request(gbns_pkg::KIND_START, 'hFFFFFF, 1, 1, 'h7FFF);
        send_request(gbns_pkg::KIND_START, 5000, 0, 0, 0);
    endtask

    task automatic test_window_slide();
        wait_all_headers();
        write_reg(gbns_pkg::CFG_SERVER_SEQ, gbns_pkg::SEQ_LIMIT);
        write_reg(gbns_pkg::CFG_CLIENT_SEQ, gbns_pkg::SEQ_LIMIT);
        send_request(gbns_pkg::KIND_START, 3 * gbns_pkg::PAYLOAD_BYTES + 7, 0, 0, 0);
        send_request(gbns_pkg::KIND_PACKET, any_size(), 1, 0, ack_for_base());
        send_request(gbns_pkg::KIND_PACKET, any_size(), 1, 0, ack_for_base() ^ 32'h4000);
        send_request(gbns_pkg::KIND_PACKET, any_size(), 0, 0, ack_for_base());
        send_request(gbns_pkg::KIND_TIMEOUT, any_size(), 0, 0, 0);
        send_request(gbns_pkg::KIND_UNUSED, any_size(), 0, 0, 0);
        // keep acking until the base runs past the end of the file
        repeat (4) send_request(gbns_pkg::KIND_PACKET, any_size(), 1, 0, ack_for_base());
    endtask

    task automatic test_fin_close();
        send_request(gbns_pkg::KIND_START, 2 * gbns_pkg::PAYLOAD_BYTES, 0, 0, 0);
        // matching ack wins over fin
        send_request(gbns_pkg::KIND_PACKET, any_size(), 1, 1, ack_for_base());
        send_request(gbns_pkg::KIND_PACKET, any_size(), 0, 1, ack_for_base());
        send_request(gbns_pkg::KIND_TIMEOUT, any_size(), 0, 0, 0);
    endtask

    task automatic test_backpressure();
        wait_all_headers();
        rx_hold = 150;
        send_request(gbns_pkg::KIND_START, 20 * gbns_pkg::PAYLOAD_BYTES, 0, 0, 0);
        repeat (4) send_request(gbns_pkg::KIND_PACKET, any_size(), 1, 0, ack_for_base());
        send_request(gbns_pkg::KIND_TIMEOUT, any_size(), 0, 0, 0);
        send_request(gbns_pkg::KIND_PACKET, any_size(), 1, 0, ack_for_base());
        wait_all_headers();
    endtask

    task automatic run_session();
        int unsigned r;
        int unsigned steps;
        int unsigned fsize;
        bit          closed;
        fsize = ($urandom_range(0, 9) == 0) ? any_size()
                                            : $urandom_range(0, 12 * gbns_pkg::PAYLOAD_BYTES);
        send_request(gbns_pkg::KIND_START, fsize, $urandom_range(0, 1),
                     $urandom_range(0, 1), any_ack());
        steps  = $urandom_range(4, 30);
        closed = 1'b0;
        while (!closed && steps > 0) begin
            steps--;
            r = $urandom_range(0, 99);
            if (r < 58) begin
                send_request(gbns_pkg::KIND_PACKET, any_size(), 1, $urandom_range(0, 1),
                             ack_for_base());
            end else if (r < 70) begin
                send_request(gbns_pkg::KIND_TIMEOUT, any_size(), $urandom_range(0, 1),
                             $urandom_range(0, 1), any_ack());
            end else if (r < 82) begin
                send_request(gbns_pkg::KIND_PACKET, any_size(), $urandom_range(0, 1), 0,
                             any_ack());
            end else if (r < 86) begin
                send_request(gbns_pkg::KIND_UNUSED, any_size(), $urandom_range(0, 1),
                             $urandom_range(0, 1), any_ack());
            end else if (r < 90) begin
                send_request(gbns_pkg::KIND_START,
                             $urandom_range(0, 8 * gbns_pkg::PAYLOAD_BYTES),
                             $urandom_range(0, 1), $urandom_range(0, 1), any_ack());
            end else begin
                send_request(gbns_pkg::KIND_PACKET, any_size(), $urandom_range(0, 1), 1,
                             any_ack());
                closed = !xfer_on;
            end
        end
        if (closed && $urandom_range(0, 2) == 0) begin
            send_request($urandom_range(0, 1) ? gbns_pkg::KIND_PACKET
                                              : gbns_pkg::KIND_TIMEOUT,
                         any_size(), $urandom_range(0, 1), $urandom_range(0, 1), any_ack());
        end
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        for (int ph = 0; ph < 5; ph++) begin
            wait_all_headers();
            case (ph)
                0: begin
                    write_reg(gbns_pkg::CFG_SERVER_SEQ, 0);
                    write_reg(gbns_pkg::CFG_CLIENT_SEQ, gbns_pkg::SEQ_LIMIT);
                end
                1: begin
                    write_reg(gbns_pkg::CFG_SERVER_SEQ, gbns_pkg::SEQ_LIMIT);
                    write_reg(gbns_pkg::CFG_CLIENT_SEQ, 0);
                end
                3: begin
                    write_reg(gbns_pkg::CFG_SERVER_SEQ, gbns_pkg::SEQ_LIMIT - 1);
                    write_reg(gbns_pkg::CFG_CLIENT_SEQ, gbns_pkg::SEQ_LIMIT - 1);
                end
                default: begin
                    write_reg(gbns_pkg::CFG_SERVER_SEQ, any_ack());
                    write_reg(gbns_pkg::CFG_CLIENT_SEQ, any_ack());
                end
            endcase
            // one phase runs with no gaps at all on the sending side
            jitter_on = (ph != 2);
            goal = accepted_items + 36;
            while (accepted_items < goal) run_session();
        end
        jitter_on = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = gbns_pkg::CFG_SERVER_SEQ;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = gbns_pkg::KIND_START;

        srv_seq        = 0;
        cli_seq        = 0;
        xfer_on        = 1'b0;
        base_idx       = 1;
        next_idx       = 1;
        pkt_total      = 0;
        tail_bytes     = 0;
        base_sn        = 0;
        next_sn        = 0;
        mismatches     = 0;
        accepted_items = 0;
        jitter_on      = 1'b1;
        rx_hold        = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_requests();
        test_start_sizes();
        test_window_slide();
        test_fin_close();
        test_backpressure();
        test_random_traffic();

        wait_all_headers();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
